FILE: src/ljpf_pkg.sv
// Shared types and constants of the Lennard-Jones pair force accumulator.
package ljpf_pkg;

  // Input item: one particle pair and the end-of-row flag
  typedef struct packed {
    logic [15:0] pos_i_x;
    logic [15:0] pos_i_y;
    logic [15:0] pos_i_z;
    logic [15:0] pos_j_x;
    logic [15:0] pos_j_y;
    logic [15:0] pos_j_z;
    logic        last_of_row;
  } in_item_t;

  // Result item: row force on particle i and row potential
  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [47:0] row_potential;
  } out_item_t;

  // Classified pair handed from front to back
  typedef struct packed {
    logic [15:0] ad_x;
    logic [15:0] ad_y;
    logic [15:0] ad_z;
    logic        neg_x;
    logic        neg_y;
    logic        neg_z;
    logic [33:0] r2;
    logic        hit;
    logic        last;
  } pair_t;

  // Configuration registers
  typedef struct packed {
    logic [23:0] well_depth;
    logic [19:0] size_param;
    logic [15:0] cutoff_radius;
  } cfg_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_WELL_DEPTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_PARAM    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_RADIUS = 2'd2;

  localparam logic [23:0] WELL_DEPTH_RST    = 24'd65536;
  localparam logic [19:0] SIZE_PARAM_RST    = 20'd65536;
  localparam logic [15:0] CUTOFF_RADIUS_RST = 16'd10240;

  // Magnitude ceiling of every intermediate product and quotient
  localparam logic [63:0] MAG_CAP = 64'h3FFF_FFFF_FFFF_FFFF;

endpackage

FILE: src/ljpf_front.sv
// Front end: accepts pairs, forms the axis distances and r2, classifies by cutoff.
module ljpf_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ljpf_pkg::in_item_t in_item_i,
  input  logic [15:0]       cutoff_i,
  input  logic              full_i,
  output logic              push_o,
  output ljpf_pkg::pair_t   pair_o
);

  logic [16:0] diff_x, diff_y, diff_z;
  logic [16:0] mag_x, mag_y, mag_z;
  logic [31:0] sq_x, sq_y, sq_z;
  logic [33:0] r2;
  logic [31:0] rc2;

  // Take an item whenever the queue has room
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  // Per-axis difference, sign and magnitude
  assign diff_x = {1'b0, in_item_i.pos_i_x} - {1'b0, in_item_i.pos_j_x};
  assign diff_y = {1'b0, in_item_i.pos_i_y} - {1'b0, in_item_i.pos_j_y};
  assign diff_z = {1'b0, in_item_i.pos_i_z} - {1'b0, in_item_i.pos_j_z};
  assign mag_x  = diff_x[16] ? (17'd0 - diff_x) : diff_x;
  assign mag_y  = diff_y[16] ? (17'd0 - diff_y) : diff_y;
  assign mag_z  = diff_z[16] ? (17'd0 - diff_z) : diff_z;

  // Squared distance and squared cutoff
  assign sq_x = 32'(mag_x[15:0]) * 32'(mag_x[15:0]);
  assign sq_y = 32'(mag_y[15:0]) * 32'(mag_y[15:0]);
  assign sq_z = 32'(mag_z[15:0]) * 32'(mag_z[15:0]);
  assign r2   = 34'(sq_x) + 34'(sq_y) + 34'(sq_z);
  assign rc2  = 32'(cutoff_i) * 32'(cutoff_i);

  // Pack the classified pair
  always_comb begin
    pair_o.ad_x  = mag_x[15:0];
    pair_o.ad_y  = mag_y[15:0];
    pair_o.ad_z  = mag_z[15:0];
    pair_o.neg_x = diff_x[16];
    pair_o.neg_y = diff_y[16];
    pair_o.neg_z = diff_z[16];
    pair_o.r2    = r2;
    pair_o.hit   = (r2 != 34'd0) && (r2 < 34'(rc2));
    pair_o.last  = in_item_i.last_of_row;
  end

endmodule

FILE: src/ljpf_queue.sv
// Two-entry queue of classified pairs between front and back.
module ljpf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ljpf_pkg::pair_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output ljpf_pkg::pair_t data_o,
  output logic            empty_o
);

  ljpf_pkg::pair_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  // Store pushed pairs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

FILE: src/ljpf_back.sv
// Back end: sequencer over a shared divider and multiplier, row accumulators, result register.
module ljpf_back #(
  parameter int POS_FRAC_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ljpf_pkg::cfg_t      cfg_i,
  input  logic                empty_i,
  input  ljpf_pkg::pair_t     pair_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ljpf_pkg::out_item_t out_item_o
);

  localparam int DW = 62 + 2 * POS_FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_DIV, ST_MUL, ST_PREP, ST_ACC, ST_EMIT
  } state_e;

  typedef enum logic [3:0] {
    OP_S2, OP_M1, OP_S6, OP_S12, OP_PMAG, OP_T, OP_T24, OP_FM, OP_FX, OP_FY, OP_FZ
  } op_e;

  typedef enum logic [1:0] {SH_32, SH_30, SH_0, SH_POS} shift_e;

  state_e  state_q;
  op_e     op_q;
  shift_e  sh_q;
  ljpf_pkg::pair_t pair_q;

  logic [DW-1:0]  w_q;
  logic [33:0]    rem_q;
  logic [CW-1:0]  cnt_q;
  logic [63:0]    a_q, b_q;
  logic [127:0]   prod_q;
  logic [2:0]     k_q;
  logic [61:0]    s2_q, s6_q, s12_q;
  logic           gneg_q;
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic signed [47:0] pot_q;
  logic signed [31:0] acc_x_q, acc_y_q, acc_z_q;
  logic signed [47:0] acc_p_q;
  logic           out_valid_q;
  ljpf_pkg::out_item_t out_q;

  logic [39:0]  sig2;
  logic [34:0]  rem_sh;
  logic         ge;
  logic [34:0]  rem_nx;
  logic [61:0]  div_res;
  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] shifted;
  logic [61:0]  mul_res;
  logic [63:0]  dif, dif_mag, g, g_mag;
  logic         dif_neg, g_neg;
  logic [63:0]  eps;

  // Clamp a signed magnitude to 32 bits
  function automatic logic signed [31:0] clamp32(input logic [61:0] mag, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (mag > 62'h8000_0000) r = 32'sh8000_0000;
      else r = $signed(32'd0 - mag[31:0]);
    end else begin
      if (mag > 62'h7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else r = $signed(mag[31:0]);
    end
    return r;
  endfunction

  // Clamp a signed magnitude to 48 bits
  function automatic logic signed [47:0] clamp48(input logic [61:0] mag, input logic neg);
    logic signed [47:0] r;
    if (neg) begin
      if (mag > 62'h8000_0000_0000) r = 48'sh8000_0000_0000;
      else r = $signed(48'd0 - mag[47:0]);
    end else begin
      if (mag > 62'h7FFF_FFFF_FFFF) r = 48'sh7FFF_FFFF_FFFF;
      else r = $signed(mag[47:0]);
    end
    return r;
  endfunction

  // Saturating 32-bit add
  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] x,
                                                   input logic signed [31:0] y);
    logic [32:0] s;
    logic signed [31:0] r;
    s = {x[31], x} + {y[31], y};
    if (s[32] != s[31]) r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else r = $signed(s[31:0]);
    return r;
  endfunction

  // Saturating 48-bit add
  function automatic logic signed [47:0] sat_add48(input logic signed [47:0] x,
                                                   input logic signed [47:0] y);
    logic [48:0] s;
    logic signed [47:0] r;
    s = {x[47], x} + {y[47], y};
    if (s[48] != s[47]) r = s[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    else r = $signed(s[47:0]);
    return r;
  endfunction

  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign sig2 = 40'(cfg_i.size_param) * 40'(cfg_i.size_param);
  assign eps  = 64'(cfg_i.well_depth);

  // One restoring division step
  assign rem_sh  = {rem_q, w_q[DW-1]};
  assign ge      = (rem_sh >= {1'b0, pair_q.r2});
  assign rem_nx  = ge ? (rem_sh - {1'b0, pair_q.r2}) : rem_sh;
  assign div_res = (w_q > DW'(ljpf_pkg::MAG_CAP)) ? ljpf_pkg::MAG_CAP[61:0] : w_q[61:0];

  // One 32x32 partial product per cycle
  always_comb begin
    case (k_q)
      3'd0:    begin a_half = a_q[31:0];  b_half = b_q[31:0];  end
      3'd1:    begin a_half = a_q[31:0];  b_half = b_q[63:32]; end
      3'd2:    begin a_half = a_q[63:32]; b_half = b_q[31:0];  end
      default: begin a_half = a_q[63:32]; b_half = b_q[63:32]; end
    endcase
  end

  assign pp = 64'(a_half) * 64'(b_half);

  always_comb begin
    case (k_q)
      3'd0:       pp_sh = {64'd0, pp};
      3'd1, 3'd2: pp_sh = {32'd0, pp, 32'd0};
      3'd3:       pp_sh = {pp, 64'd0};
      default:    pp_sh = '0;
    endcase
  end

  // Scale the finished product and cap it
  always_comb begin
    case (sh_q)
      SH_32:   shifted = prod_q >> 32;
      SH_30:   shifted = prod_q >> 30;
      SH_0:    shifted = prod_q;
      default: shifted = prod_q >> POS_FRAC_BITS;
    endcase
  end

  assign mul_res = (shifted > {64'd0, ljpf_pkg::MAG_CAP}) ? ljpf_pkg::MAG_CAP[61:0]
                                                          : shifted[61:0];

  // s12 - s6 and 2*s12 - s6 as sign and magnitude
  assign dif     = {2'b00, s12_q} - {2'b00, s6_q};
  assign dif_neg = dif[63];
  assign dif_mag = dif_neg ? (64'd0 - dif) : dif;
  assign g       = {1'b0, s12_q, 1'b0} - {2'b00, s6_q};
  assign g_neg   = g[63];
  assign g_mag   = g_neg ? (64'd0 - g) : g;

  // Sequencer, shared units, accumulators and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_S2;
      cnt_q       <= '0;
      k_q         <= 3'd0;
      out_valid_q <= 1'b0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_z_q     <= '0;
      acc_p_q     <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            pair_q  <= pair_i;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (pair_q.hit) begin
            w_q     <= DW'(sig2) << (2 * POS_FRAC_BITS);
            rem_q   <= '0;
            cnt_q   <= CW'(DW);
            op_q    <= OP_S2;
            state_q <= ST_DIV;
          end else begin
            cx_q    <= '0;
            cy_q    <= '0;
            cz_q    <= '0;
            pot_q   <= '0;
            state_q <= ST_ACC;
          end
        end
        ST_DIV: begin
          if (cnt_q != '0) begin
            w_q   <= {w_q[DW-2:0], ge};
            rem_q <= rem_nx[33:0];
            cnt_q <= cnt_q - CW'(1);
          end else begin
            prod_q  <= '0;
            k_q     <= 3'd0;
            a_q     <= 64'(div_res);
            state_q <= ST_MUL;
            if (op_q == OP_S2) begin
              s2_q <= div_res;
              b_q  <= 64'(div_res);
              sh_q <= SH_32;
              op_q <= OP_M1;
            end else begin
              b_q  <= 64'(pair_q.ad_x);
              sh_q <= SH_POS;
              op_q <= OP_FX;
            end
          end
        end
        ST_MUL: begin
          if (k_q != 3'd4) begin
            prod_q <= prod_q + pp_sh;
            k_q    <= k_q + 3'd1;
          end else begin
            prod_q <= '0;
            k_q    <= 3'd0;
            case (op_q)
              OP_M1: begin
                a_q  <= 64'(mul_res);
                b_q  <= 64'(s2_q);
                op_q <= OP_S6;
              end
              OP_S6: begin
                s6_q <= mul_res;
                a_q  <= 64'(mul_res);
                b_q  <= 64'(mul_res);
                op_q <= OP_S12;
              end
              OP_S12: begin
                s12_q   <= mul_res;
                state_q <= ST_PREP;
              end
              OP_PMAG: begin
                pot_q  <= clamp48(mul_res, dif_neg);
                gneg_q <= g_neg;
                a_q    <= eps;
                b_q    <= g_mag;
                sh_q   <= SH_32;
                op_q   <= OP_T;
              end
              OP_T: begin
                a_q  <= 64'(mul_res);
                b_q  <= 64'd24;
                sh_q <= SH_0;
                op_q <= OP_T24;
              end
              OP_T24: begin
                w_q     <= DW'(mul_res) << (2 * POS_FRAC_BITS);
                rem_q   <= '0;
                cnt_q   <= CW'(DW);
                op_q    <= OP_FM;
                state_q <= ST_DIV;
              end
              OP_FX: begin
                cx_q <= clamp32(mul_res, gneg_q ^ pair_q.neg_x);
                b_q  <= 64'(pair_q.ad_y);
                op_q <= OP_FY;
              end
              OP_FY: begin
                cy_q <= clamp32(mul_res, gneg_q ^ pair_q.neg_y);
                b_q  <= 64'(pair_q.ad_z);
                op_q <= OP_FZ;
              end
              OP_FZ: begin
                cz_q    <= clamp32(mul_res, gneg_q ^ pair_q.neg_z);
                state_q <= ST_ACC;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_PREP: begin
          a_q     <= eps;
          b_q     <= dif_mag;
          sh_q    <= SH_30;
          op_q    <= OP_PMAG;
          state_q <= ST_MUL;
        end
        ST_ACC: begin
          acc_x_q <= sat_add32(acc_x_q, cx_q);
          acc_y_q <= sat_add32(acc_y_q, cy_q);
          acc_z_q <= sat_add32(acc_z_q, cz_q);
          acc_p_q <= sat_add48(acc_p_q, pot_q);
          state_q <= pair_q.last ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.force_x       <= acc_x_q;
            out_q.force_y       <= acc_y_q;
            out_q.force_z       <= acc_z_q;
            out_q.row_potential <= acc_p_q;
            out_valid_q         <= 1'b1;
            acc_x_q             <= '0;
            acc_y_q             <= '0;
            acc_z_q             <= '0;
            acc_p_q             <= '0;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Divider count runs only while dividing
  a_cnt_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (state_q == ST_DIV))
    else $error("divider count active outside division");

  // A fresh result leaves cleared accumulators behind
  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (acc_x_q == '0 && acc_y_q == '0 && acc_z_q == '0
                            && acc_p_q == '0))
    else $error("accumulators not cleared on result");

  // Only a row end may wait to emit
  a_emit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> pair_q.last)
    else $error("emit without end of row");

  // Partial product counter stays in range
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (k_q <= 3'd4))
    else $error("partial product counter out of range");

endmodule

FILE: src/lennard_jones_pair_force_accumulator_unit.sv
// Top level of the Lennard-Jones 12-6 pair force accumulator with cutoff.
//
// Input channel (in_valid_i / in_stall_i-style stall out on in_stall_o) takes one
// particle pair per item; last_of_row closes the row of particle i. Result channel
// (out_valid_o / out_stall_i) gives one item per closed row: the saturated force
// sums and the row potential. Configuration: cfg_we_i writes register cfg_idx_i
// (0 well_depth, 1 size_param, 2 cutoff_radius) with cfg_data_i. The front
// classifies an item in the cycle it is taken and a two-entry queue holds it for
// the back. The back handles one pair at a time: a pair outside the cutoff goes
// straight from the check to accumulation; one inside runs the bit-serial divider
// twice and nine passes of the 32x32 multiplier. A row end adds an emit step.
// Reset clears the accumulators, queue and result valid flag and loads the register
// defaults. While the receiver stalls, the result holds; the back keeps working
// and waits only when a later row end finds the result register still full.
module lennard_jones_pair_force_accumulator_unit #(
  parameter int POS_FRAC_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ljpf_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ljpf_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [ljpf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ljpf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  ljpf_pkg::cfg_t  cfg_q;
  ljpf_pkg::pair_t front_pair, queue_pair;
  logic            push, full, pop, empty;

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.well_depth    <= ljpf_pkg::WELL_DEPTH_RST;
      cfg_q.size_param    <= ljpf_pkg::SIZE_PARAM_RST;
      cfg_q.cutoff_radius <= ljpf_pkg::CUTOFF_RADIUS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ljpf_pkg::CFG_WELL_DEPTH:    cfg_q.well_depth    <= cfg_data_i;
        ljpf_pkg::CFG_SIZE_PARAM:    cfg_q.size_param    <= cfg_data_i[19:0];
        ljpf_pkg::CFG_CUTOFF_RADIUS: cfg_q.cutoff_radius <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  ljpf_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .cutoff_i   (cfg_q.cutoff_radius),
    .full_i     (full),
    .push_o     (push),
    .pair_o     (front_pair)
  );

  ljpf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_pair),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (queue_pair),
    .empty_o (empty)
  );

  ljpf_back #(
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .pair_i      (queue_pair),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
